/* rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and codes for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int unsigned ReqDataBits = 136;
   localparam int unsigned RspDataBits = 72;

   typedef enum logic [2:0] {
      OP_NORM = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_LT   = 3'd5,
      OP_EQ   = 3'd6,
      OP_NONE = 3'd7
   } rau_op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ZDEN = 2'd1,
      ST_DIVZ = 2'd2,
      ST_OVF  = 2'd3
   } rau_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHK,
      S_MUL,
      S_SUM,
      S_MAG,
      S_GEVEN,
      S_GODD,
      S_DIVN,
      S_DIVD,
      S_CHECK,
      S_FIN
   } rau_state_type;

endpackage

/* rtl/rational_arith_unit_core.sv */
// ----------------------------------------------------------------------------
// rational_arith_unit_core
// exact add, subtract, multiply, divide, compare and normalize on fractions
// ----------------------------------------------------------------------------
// usage
//   req_* carries one operation beat: an op code and two fractions a and b.
//   rsp_* returns one beat per request: reduced numerator and positive
//   denominator, a compare flag and a status code (ok, zero denominator,
//   division by zero, overflow). errors and compares return 0/1.
// timing
//   one request at a time; req_tready is high only while the sequencer idles.
//   a shared 33x33 multiplier forms the products, then a binary gcd loop
//   (one compare/subtract per cycle) and two bit-serial restoring divisions
//   by the gcd reduce the result. a zero numerator, error cases and
//   compares skip the reduction.
// stalls and reset
//   the result sits in an output register; a new request is taken while it
//   waits. the sequencer holds its last result if the register is still full.
//   synchronous reset returns to idle and empties the output register.
// ----------------------------------------------------------------------------
module rational_arith_unit_core #(
   parameter int VALUE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // op[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[129:99]
   input  logic [rau_pkg::ReqDataBits-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // res_num[31:0], res_den[62:32], flag[63], status[65:64]
   output logic [rau_pkg::RspDataBits-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);
   import rau_pkg::*;

   localparam logic [63:0] MagLimit = (64'd1 << (VALUE_BITS - 1)) - 64'd1;

   rau_state_type state_ff, state_in;

   // captured operands
   logic [2:0]         op_ff, op_in;
   logic signed [31:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in;
   logic [30:0]        bd_ff, bd_in;

   // products and sum
   logic signed [63:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic signed [63:0] num_ff, num_in;
   logic [1:0]         idx_ff, idx_in;

   // gcd and divide
   logic [63:0] u_ff, u_in, v_ff, v_in, nq_ff, nq_in, dq_ff, dq_in;
   logic [63:0] dvs_ff, dvs_in, q_ff, q_in, rem_ff, rem_in, nres_ff, nres_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;

   // result staging and output register
   logic [31:0]        r_num_ff, r_num_in;
   logic [30:0]        r_den_ff, r_den_in;
   logic               r_flag_ff, r_flag_in;
   rau_status_type     r_st_ff, r_st_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RspDataBits-1:0] rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic signed [32:0] mx, my;
   logic signed [65:0] prod;

   // shared divide step
   logic [64:0] rem_sh, rem_diff;
   logic        rem_ge;

   logic early, out_free, cmp_op;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cmp_op     = (op_ff == OP_LT) || (op_ff == OP_EQ);

   assign early = (op_ff == OP_NONE) || (ad_ff == 32'sd0) ||
                  ((op_ff != OP_NORM) && (bd_ff == 31'd0)) ||
                  ((op_ff == OP_DIV) && (bn_ff == 32'sd0));

   // operand select per op and product index
   always_comb begin
      unique case (idx_ff)
         2'd0: begin
            mx = 33'(an_ff);
            if (op_ff == OP_MUL) my = 33'(bn_ff);
            else if (op_ff == OP_NORM) my = 33'sd1;
            else my = $signed({2'b00, bd_ff});
         end
         2'd1: begin
            mx = 33'(ad_ff);
            if (op_ff == OP_DIV) my = 33'(bn_ff);
            else if (op_ff == OP_NORM) my = 33'sd1;
            else my = $signed({2'b00, bd_ff});
         end
         default: begin
            mx = 33'(bn_ff);
            my = 33'(ad_ff);
         end
      endcase
   end

   assign prod = mx * my;

   assign rem_sh   = {rem_ff, q_ff[63]};
   assign rem_ge   = rem_sh >= {1'b0, dvs_ff};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_CHK;
         S_CHK:   state_in = early ? S_FIN : S_MUL;
         S_MUL:   if (idx_ff == 2'd2) state_in = S_SUM;
         S_SUM:   state_in = cmp_op ? S_FIN : S_MAG;
         S_MAG:   state_in = (num_ff == 64'sd0) ? S_FIN : S_GEVEN;
         S_GEVEN: if (u_ff[0] || v_ff[0]) state_in = S_GODD;
         S_GODD:  if (u_ff == 64'd0 || v_ff == 64'd0) state_in = S_DIVN;
         S_DIVN:  if (cnt_ff == 6'd63) state_in = S_DIVD;
         S_DIVD:  if (cnt_ff == 6'd63) state_in = S_CHECK;
         S_CHECK: state_in = S_FIN;
         S_FIN:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      op_in = op_ff; an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff; num_in = num_ff;
      idx_in = idx_ff;
      u_in = u_ff; v_in = v_ff; nq_in = nq_ff; dq_in = dq_ff; dvs_in = dvs_ff;
      q_in = q_ff; rem_in = rem_ff; nres_in = nres_ff; neg_in = neg_ff;
      cnt_in = cnt_ff;
      r_num_in = r_num_ff; r_den_in = r_den_ff; r_flag_in = r_flag_ff;
      r_st_in = r_st_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tdata[2:0];
               an_in = $signed(req_tdata[34:3]);
               ad_in = $signed(req_tdata[66:35]);
               bn_in = $signed(req_tdata[98:67]);
               bd_in = req_tdata[129:99];
            end
            idx_in = 2'd0;
         end
         S_CHK: begin
            // default result for error, unused op and compare paths
            r_num_in  = 32'd0;
            r_den_in  = 31'd1;
            r_flag_in = 1'b0;
            priority if (op_ff == OP_NONE) r_st_in = ST_OK;
            else if (ad_ff == 32'sd0 || (op_ff != OP_NORM && bd_ff == 31'd0))
               r_st_in = ST_ZDEN;
            else if (op_ff == OP_DIV && bn_ff == 32'sd0) r_st_in = ST_DIVZ;
            else r_st_in = ST_OK;
         end
         S_MUL: begin
            unique case (idx_ff)
               2'd0:    p0_in = prod[63:0];
               2'd1:    p1_in = prod[63:0];
               default: p2_in = prod[63:0];
            endcase
            idx_in = idx_ff + 2'd1;
         end
         S_SUM: begin
            if (op_ff == OP_LT)
               r_flag_in = (ad_ff > 32'sd0) ? (p0_ff < p2_ff) : (p0_ff > p2_ff);
            else if (op_ff == OP_EQ)
               r_flag_in = (p0_ff == p2_ff);
            if (op_ff == OP_ADD) num_in = p0_ff + p2_ff;
            else if (op_ff == OP_SUB) num_in = p0_ff - p2_ff;
            else num_in = p0_ff;
         end
         S_MAG: begin
            neg_in = num_ff[63] ^ p1_ff[63];
            u_in   = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
            v_in   = p1_ff[63] ? 64'(-p1_ff) : 64'(p1_ff);
         end
         S_GEVEN: begin
            // strip common powers of two, they divide out exactly
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
            end else begin
               nq_in = u_ff;
               dq_in = v_ff;
            end
         end
         S_GODD: begin
            priority if (v_ff == 64'd0 || u_ff == 64'd0) begin
               dvs_in = (u_ff == 64'd0) ? v_ff : u_ff;
               q_in   = nq_ff;
               rem_in = 64'd0;
               cnt_in = 6'd0;
            end else if (!u_ff[0]) u_in = u_ff >> 1;
            else if (!v_ff[0]) v_in = v_ff >> 1;
            else if (u_ff >= v_ff) u_in = (u_ff - v_ff) >> 1;
            else v_in = (v_ff - u_ff) >> 1;
         end
         S_DIVN, S_DIVD: begin
            rem_in = rem_ge ? rem_diff[63:0] : rem_sh[63:0];
            q_in   = {q_ff[62:0], rem_ge};
            cnt_in = cnt_ff + 6'd1;
            if (state_ff == S_DIVN && cnt_ff == 6'd63) begin
               nres_in = {q_ff[62:0], rem_ge};
               q_in    = dq_ff;
               rem_in  = 64'd0;
            end
         end
         S_CHECK: begin
            if (nres_ff > MagLimit || q_ff > MagLimit) begin
               r_st_in = ST_OVF;
            end else begin
               r_num_in = neg_ff ? (32'd0 - nres_ff[31:0]) : nres_ff[31:0];
               r_den_in = q_ff[30:0];
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, r_st_ff, r_flag_ff, r_den_ff, r_num_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         cnt_ff       <= 6'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in; num_ff <= num_in;
      u_ff <= u_in; v_ff <= v_in; nq_ff <= nq_in; dq_ff <= dq_in; dvs_ff <= dvs_in;
      q_ff <= q_in; rem_ff <= rem_in; nres_ff <= nres_in; neg_ff <= neg_in;
      r_num_ff <= r_num_in; r_den_ff <= r_den_in; r_flag_ff <= r_flag_in;
      r_st_ff <= r_st_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // any error status comes with a 0/1 result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[65:64] != ST_OK) |->
      (rsp_data_ff[31:0] == 32'd0) && (rsp_data_ff[62:32] == 31'd1)
                                   && !rsp_data_ff[63])
      else $error("error result not 0/1");

   // a set compare flag never comes with a fraction or an error
   a_flag_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[63] |->
      (rsp_data_ff[65:64] == ST_OK) && (rsp_data_ff[31:0] == 32'd0))
      else $error("compare flag with fraction");

   // the divisor is never zero while dividing
   a_dvs_nz: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVN || state_ff == S_DIVD) |-> (dvs_ff != 64'd0))
      else $error("zero divisor in reduction");

   // an accepted request leaves idle at once
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after accept");
`endif

endmodule

/* tb/tb_rational_arith_unit_core.sv */
// ----------------------------------------------------------------------------
// tb_rational_arith_unit_core
// self-checking bench: directed and random fraction operations, with a
// scoreboard that predicts each reduced result and compares it field by field
// ----------------------------------------------------------------------------
module tb_rational_arith_unit_core;
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   typedef struct packed {
      logic [30:0] b_den;
      logic [31:0] b_num;
      logic [31:0] a_den;
      logic [31:0] a_num;
      rau_op_type  op;
   } frac_req_type;

   typedef struct packed {
      rau_status_type status;
      logic           flag;
      logic [30:0]    res_den;
      logic [31:0]    res_num;
   } frac_rsp_type;

   // scoreboard: predicts the reduced fraction for each accepted request
   class frac_scoreboard;
      frac_rsp_type pending[$];
      int           mismatches;

      function automatic frac_rsp_type fixed(logic [31:0] n, logic [30:0] d,
                                             logic f, rau_status_type s);
         frac_rsp_type r;
         r.res_num = n;
         r.res_den = d;
         r.flag    = f;
         r.status  = s;
         return r;
      endfunction

      function automatic longint unsigned gcd_of(longint unsigned x,
                                                 longint unsigned y);
         longint unsigned t;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         return x;
      endfunction

      function automatic frac_rsp_type reduce(longint num, longint den);
         longint unsigned n, d, g;
         bit              neg;
         neg = (num < 0) != (den < 0);
         n = (num < 0) ? -num : num;
         d = (den < 0) ? -den : den;
         if (n == 0) return fixed(32'd0, 31'd1, 1'b0, ST_OK);
         g = gcd_of(n, d);
         n = n / g;
         d = d / g;
         if (n > 64'h7FFF_FFFF || d > 64'h7FFF_FFFF)
            return fixed(32'd0, 31'd1, 1'b0, ST_OVF);
         return fixed(neg ? -n[31:0] : n[31:0], d[30:0], 1'b0, ST_OK);
      endfunction

      function automatic frac_rsp_type predict(frac_req_type q);
         longint an, ad, bn, bd;
         an = longint'(signed'(q.a_num));
         ad = longint'(signed'(q.a_den));
         bn = longint'(signed'(q.b_num));
         bd = longint'({1'b0, q.b_den});
         if (q.op == OP_NONE) return fixed(32'd0, 31'd1, 1'b0, ST_OK);
         if (ad == 0 || (q.op != OP_NORM && bd == 0))
            return fixed(32'd0, 31'd1, 1'b0, ST_ZDEN);
         case (q.op)
            OP_NORM: return reduce(an, ad);
            OP_ADD:  return reduce(an * bd + bn * ad, ad * bd);
            OP_SUB:  return reduce(an * bd - bn * ad, ad * bd);
            OP_MUL:  return reduce(an * bn, ad * bd);
            OP_DIV: begin
               if (bn == 0) return fixed(32'd0, 31'd1, 1'b0, ST_DIVZ);
               return reduce(an * bd, ad * bn);
            end
            OP_LT: return fixed(32'd0, 31'd1,
                                (ad > 0) ? (an * bd < bn * ad) : (an * bd > bn * ad), ST_OK);
            default: return fixed(32'd0, 31'd1, an * bd == bn * ad, ST_OK);
         endcase
      endfunction

      function void note_request(frac_req_type q);
         pending.push_back(predict(q));
      endfunction

      function void check_result(frac_rsp_type got);
         frac_rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
         end
         want = pending.pop_front();
         if (got.res_num !== want.res_num || got.res_den !== want.res_den ||
             got.flag !== want.flag || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %0d/%0d flag %0b st %0d, got %0d/%0d flag %0b st %0d",
                        signed'(want.res_num), want.res_den, want.flag, want.status,
                        signed'(got.res_num), got.res_den, got.flag, got.status);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [ReqDataBits-1:0] req_tdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RspDataBits-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   frac_scoreboard sb = new();
   bit             hold_off = 1'b0;    // long receiver stall while requests keep coming

   rational_arith_unit_core dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 400);
   endfunction

   // random 32-bit value biased toward edges and small magnitudes
   function automatic logic [31:0] pick_val();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 12);
         1: return -$urandom_range(1, 12);
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0001;
         3: return $urandom_range(0, 1) ? $urandom_range(0, 70000) : -$urandom_range(0, 70000);
         default: return $urandom();
      endcase
   endfunction

   // one request beat, fields as given; sample acceptance at rising edge
   task automatic send(rau_op_type op, logic [31:0] an, logic [31:0] ad,
                       logic [31:0] bn, logic [30:0] bd);
      frac_req_type q;
      q.op = op; q.a_num = an; q.a_den = ad; q.b_num = bn; q.b_den = bd;
      req_tdata  = ReqDataBits'(q);
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(q);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_random();
      logic [31:0] ad;
      logic [30:0] bd;
      int          g;
      ad = pick_val();
      bd = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(1, 20)) : 31'(pick_val());
      if ($urandom_range(0, 40) == 0) ad = 32'd0;
      if ($urandom_range(0, 40) == 0) bd = 31'd0;
      send(rau_op_type'($urandom_range(0, 7)), pick_val(), ad, pick_val(), bd);
      g = gap_len();
      repeat (g) @(negedge clock);
   endtask

   // receiver: random ready, with one long hold-off
   initial begin
      int g;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (2000) @(negedge clock);
            hold_off = 1'b0;
         end
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(frac_rsp_type'(rsp_tdata[65:0]));

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every op, field extremes, errors, negative a_den, equal dens
      send(OP_NORM, 32'd6, -32'd4, 32'd0, 31'd1);
      send(OP_NORM, 32'h8000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      send(OP_NORM, 32'd0, -32'd5, 32'd0, 31'd0);
      send(OP_NORM, 32'd3, 32'd0, 32'd1, 31'd1);
      send(OP_ADD, 32'd1, 32'd2, 32'd1, 31'd3);
      send(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 31'd1);
      send(OP_ADD, 32'd1, 32'd2, 32'd1, 31'd0);
      send(OP_SUB, 32'd1, -32'd3, 32'd2, 31'd3);
      send(OP_SUB, 32'h8000_0001, 32'd1, 32'h7FFF_FFFF, 31'd1);
      send(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001, 31'h7FFF_FFFF);
      send(OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 31'd1);
      send(OP_DIV, 32'd3, 32'd4, 32'd0, 31'd5);
      send(OP_DIV, 32'd3, 32'd0, 32'd0, 31'd5);
      send(OP_DIV, -32'd3, 32'd4, -32'd9, 31'd8);
      send(OP_LT, 32'd1, 32'd3, 32'd2, 31'd3);
      send(OP_LT, 32'd2, 32'd3, 32'd1, 31'd3);
      send(OP_LT, 32'd1, -32'd3, 32'd1, 31'd3);
      send(OP_LT, 32'h8000_0001, 32'd1, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      send(OP_EQ, 32'd2, 32'd4, 32'd1, 31'd2);
      send(OP_EQ, 32'd2, -32'd4, 32'd1, 31'd2);
      send(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);

      // long receiver stall while requests keep coming
      hold_off = 1'b1;
      repeat (8) send_random();

      // pause until drained
      while (sb.pending.size() != 0) @(negedge clock);

      repeat (1080) send_random();

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("rational_arith_unit_core verification clean");
      else
         $display("rational_arith_unit_core verification failed");
      $finish;
   end

   initial begin
      #100ms;
      $display("rational_arith_unit_core verification failed");
      $finish;
   end

endmodule

/* rational_arith_unit_core.f */
rtl/rau_pkg.sv
rtl/rational_arith_unit_core.sv
tb/tb_rational_arith_unit_core.sv
